// ===== rtl/core/ebc_pkg.sv =====
package ebc_pkg;

    // Request codes
    localparam logic [1:0] REQ_EXEC  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Operand code for the (HL) memory operand
    localparam logic [2:0] OPND_MEM = 3'd6;

    // Register reset values
    localparam logic [7:0]  RST_A  = 8'h01;
    localparam logic [7:0]  RST_F  = 8'hB0;
    localparam logic [15:0] RST_BC = 16'h0013;
    localparam logic [15:0] RST_DE = 16'h00D8;
    localparam logic [15:0] RST_HL = 16'h014D;
    localparam logic [15:0] RST_SP = 16'hFFFE;
    localparam logic [15:0] RST_PC = 16'h0100;
    localparam logic [7:0]  HIGH_PAGE = 8'hFF;

    // Handled opcodes outside the regular blocks
    localparam logic [7:0] OP_LD_A_BC   = 8'h0A;
    localparam logic [7:0] OP_LD_A_DE   = 8'h1A;
    localparam logic [7:0] OP_LD_A_NN   = 8'hFA;
    localparam logic [7:0] OP_LD_BC_A   = 8'h02;
    localparam logic [7:0] OP_LD_DE_A   = 8'h12;
    localparam logic [7:0] OP_LD_NN_A   = 8'hEA;
    localparam logic [7:0] OP_LD_A_CIO  = 8'hF2;
    localparam logic [7:0] OP_LD_CIO_A  = 8'hE2;
    localparam logic [7:0] OP_LD_A_HLD  = 8'h3A;
    localparam logic [7:0] OP_LD_HLD_A  = 8'h32;
    localparam logic [7:0] OP_LD_A_HLI  = 8'h2A;
    localparam logic [7:0] OP_LD_HLI_A  = 8'h22;
    localparam logic [7:0] OP_LDH_N_A   = 8'hE0;
    localparam logic [7:0] OP_LDH_A_N   = 8'hF0;
    localparam logic [7:0] OP_LD_BC_NN  = 8'h01;
    localparam logic [7:0] OP_LD_DE_NN  = 8'h11;
    localparam logic [7:0] OP_LD_HL_NN  = 8'h21;
    localparam logic [7:0] OP_LD_SP_NN  = 8'h31;
    localparam logic [7:0] OP_LD_SP_HL  = 8'hF9;
    localparam logic [7:0] OP_LD_HL_SPE = 8'hF8;
    localparam logic [7:0] OP_LD_NN_SP  = 8'h08;
    localparam logic [7:0] OP_HALT      = 8'h76;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_IMM1,
        ST_IMM2,
        ST_DATA,
        ST_DATA2,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/eight_bit_cpu_load_store_unit.sv =====
// Channel  | Direction | Handshake           | Payload
// request  | in        | i_start and !o_busy | i_req_type, i_host_addr, i_host_data
// result   | out       | o_done strobe       | o_cycles .. o_prog_ctr
//
// A host write completes in the fetch state; a host read also passes the done state.
// An instruction passes the fetch, decode, immediate and data states, reading each
// immediate byte in turn, plus the done state for a memory read and the SP store's high
// byte, as the single byte-memory port serves fetches and data one at a time.
// Reset clears the register file to its power-on values; memory is not cleared.
// The result stands for one cycle with o_done and cannot be stalled; a new request
// may be accepted in that same cycle.
module eight_bit_cpu_load_store_unit #(
    parameter int MEM_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_host_addr,
    input  logic [7:0]  i_host_data,
    output logic        o_done,
    output logic [4:0]  o_cycles,
    output logic        o_unknown_opcode,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_acc,
    output logic [7:0]  o_flags,
    output logic [15:0] o_pair_bc,
    output logic [15:0] o_pair_de,
    output logic [15:0] o_pair_hl,
    output logic [15:0] o_stack_ptr,
    output logic [15:0] o_prog_ctr
);
    import ebc_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    // Byte memory, one port, registered read
    logic [7:0]    r_mem [MEM_DEPTH];
    logic [7:0]    r_rdata;
    logic          mem_we;
    logic [15:0]   mem_addr;
    logic [7:0]    mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr[AW-1:0]] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr[AW-1:0]];
    end

    // Registers
    t_state      r_state, n_state;
    logic [7:0]  r_a, n_a, r_f, n_f;
    logic [15:0] r_bc, n_bc, r_de, n_de, r_hl, n_hl, r_sp, n_sp, r_pc, n_pc;
    logic [1:0]  r_req;
    logic [15:0] r_haddr;
    logic [7:0]  r_hdata;
    logic [7:0]  r_op, n_op;
    logic [7:0]  r_lo, n_lo, r_hi, n_hi;
    logic [4:0]  r_cyc, n_cyc;
    logic        r_unk, n_unk;
    logic [7:0]  r_rd, n_rd;
    logic        r_done, n_done;

    // Decode of the held opcode
    logic [2:0] dst, src;
    logic       is_rr, is_rn;
    logic [1:0] n_imm;
    logic       needs_data;
    logic [4:0] dec_cyc;
    logic [7:0] src_val;
    logic [15:0] nn;
    logic [15:0] ext;
    logic [4:0]  sum_nib;
    logic [8:0]  sum_low;

    assign dst   = r_op[5:3];
    assign src   = r_op[2:0];
    assign is_rr = (r_op[7:6] == 2'b01) && (r_op != OP_HALT);
    assign is_rn = (r_op[7:6] == 2'b00) && (src == OPND_MEM);
    assign nn    = {r_hi, r_lo};
    assign ext   = {{8{r_lo[7]}}, r_lo};
    assign sum_nib = {1'b0, r_sp[3:0]} + {1'b0, r_lo[3:0]};
    assign sum_low = {1'b0, r_sp[7:0]} + {1'b0, r_lo};

    // Instruction length, data access need and cycle count
    always_comb begin
        n_imm = 2'd0;
        needs_data = 1'b0;
        dec_cyc = 5'd0;
        if (is_rr) begin
            needs_data = (dst == OPND_MEM) || (src == OPND_MEM);
            dec_cyc = needs_data ? 5'd8 : 5'd4;
        end else if (is_rn) begin
            n_imm = 2'd1;
            needs_data = (dst == OPND_MEM);
            dec_cyc = needs_data ? 5'd12 : 5'd8;
        end else begin
            unique case (r_op)
                OP_LD_A_BC, OP_LD_A_DE, OP_LD_BC_A, OP_LD_DE_A, OP_LD_A_CIO,
                OP_LD_CIO_A, OP_LD_A_HLD, OP_LD_HLD_A, OP_LD_A_HLI,
                OP_LD_HLI_A: begin
                    needs_data = 1'b1;
                    dec_cyc = 5'd8;
                end
                OP_LD_A_NN, OP_LD_NN_A: begin
                    n_imm = 2'd2; needs_data = 1'b1; dec_cyc = 5'd16;
                end
                OP_LDH_N_A, OP_LDH_A_N: begin
                    n_imm = 2'd1; needs_data = 1'b1; dec_cyc = 5'd12;
                end
                OP_LD_BC_NN, OP_LD_DE_NN, OP_LD_HL_NN, OP_LD_SP_NN: begin
                    n_imm = 2'd2; dec_cyc = 5'd12;
                end
                OP_LD_SP_HL: dec_cyc = 5'd8;
                OP_LD_HL_SPE: begin
                    n_imm = 2'd1; dec_cyc = 5'd12;
                end
                OP_LD_NN_SP: begin
                    n_imm = 2'd2; needs_data = 1'b1; dec_cyc = 5'd20;
                end
                default: dec_cyc = 5'd0;
            endcase
        end
    end

    // Register operand value
    always_comb begin
        case (src)
            3'd0: src_val = r_bc[15:8];
            3'd1: src_val = r_bc[7:0];
            3'd2: src_val = r_de[15:8];
            3'd3: src_val = r_de[7:0];
            3'd4: src_val = r_hl[15:8];
            3'd5: src_val = r_hl[7:0];
            3'd6: src_val = r_rdata;
            default: src_val = r_a;
        endcase
    end

    // Data access address for the opcode
    logic [15:0] data_addr;
    always_comb begin
        if (is_rr || is_rn) begin
            data_addr = r_hl;
        end else begin
            case (r_op)
                OP_LD_A_BC, OP_LD_BC_A: data_addr = r_bc;
                OP_LD_A_DE, OP_LD_DE_A: data_addr = r_de;
                OP_LD_A_CIO, OP_LD_CIO_A: data_addr = {HIGH_PAGE, r_bc[7:0]};
                OP_LDH_N_A, OP_LDH_A_N: data_addr = {HIGH_PAGE, r_lo};
                OP_LD_A_NN, OP_LD_NN_A, OP_LD_NN_SP: data_addr = nn;
                default: data_addr = r_hl;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_a <= RST_A; r_f <= RST_F; r_bc <= RST_BC; r_de <= RST_DE;
            r_hl <= RST_HL; r_sp <= RST_SP; r_pc <= RST_PC;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_a <= n_a; r_f <= n_f; r_bc <= n_bc; r_de <= n_de;
            r_hl <= n_hl; r_sp <= n_sp; r_pc <= n_pc;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_req   <= i_req_type;
            r_haddr <= i_host_addr;
            r_hdata <= i_host_data;
        end
        r_op <= n_op; r_lo <= n_lo; r_hi <= n_hi;
        r_cyc <= n_cyc; r_unk <= n_unk; r_rd <= n_rd;
    end

    always_comb begin
        n_state = r_state;
        n_a = r_a; n_f = r_f; n_bc = r_bc; n_de = r_de;
        n_hl = r_hl; n_sp = r_sp; n_pc = r_pc;
        n_op = r_op; n_lo = r_lo; n_hi = r_hi;
        n_cyc = r_cyc; n_unk = r_unk; n_rd = r_rd;
        n_done = 1'b0;
        mem_we = 1'b0;
        mem_addr = r_pc;
        mem_wdata = r_a;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cyc = 5'd0; n_unk = 1'b0; n_rd = 8'd0;
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // Opcode read for execute, or the host access
                if (r_req == REQ_EXEC) begin
                    mem_addr = r_pc;
                    n_pc = r_pc + 16'd1;
                    n_state = ST_DECODE;
                end else if (r_req == REQ_WRITE) begin
                    mem_addr = r_haddr; mem_wdata = r_hdata; mem_we = 1'b1;
                    n_done = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_req == REQ_READ) begin
                    mem_addr = r_haddr;
                    n_state = ST_DONE;
                end else begin
                    n_done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DECODE: begin
                n_op = r_rdata;
                n_state = ST_IMM1;
            end
            ST_IMM1: begin
                // Opcode known; start the first immediate read or move on to the data access
                n_cyc = dec_cyc;
                n_unk = (dec_cyc == 5'd0);
                if (n_imm != 2'd0) begin
                    mem_addr = r_pc;
                    n_pc = r_pc + 16'd1;
                    n_state = ST_IMM2;
                end else begin
                    n_state = ST_DATA;
                end
                n_hi = {6'd0, n_imm};
            end
            ST_IMM2: begin
                // r_hi holds the count of immediates in this step
                n_lo = r_rdata;
                if (r_hi == 8'd2) begin
                    mem_addr = r_pc;
                    n_pc = r_pc + 16'd1;
                    n_hi = 8'd1;
                    n_state = ST_DATA2;
                end else begin
                    n_state = ST_DATA;
                end
            end
            ST_DATA2: begin
                n_lo = r_lo;
                n_hi = r_rdata;
                n_state = ST_DATA;
            end
            ST_DATA: begin
                // Reads and writes of data, or register-only completion
                mem_addr = data_addr;
                if (r_unk) begin
                    n_done = 1'b1;
                    n_state = ST_IDLE;
                end else if (needs_data) begin
                    if ((is_rr && dst == OPND_MEM) || (is_rn && dst == OPND_MEM)) begin
                        mem_we = 1'b1;
                        mem_wdata = is_rn ? r_lo : src_val;
                        n_done = 1'b1;
                        n_state = ST_IDLE;
                    end else if (r_op == OP_LD_BC_A || r_op == OP_LD_DE_A
                                 || r_op == OP_LD_CIO_A || r_op == OP_LDH_N_A
                                 || r_op == OP_LD_NN_A || r_op == OP_LD_HLD_A
                                 || r_op == OP_LD_HLI_A) begin
                        mem_we = 1'b1;
                        if (r_op == OP_LD_HLD_A) n_hl = r_hl - 16'd1;
                        if (r_op == OP_LD_HLI_A) n_hl = r_hl + 16'd1;
                        n_done = 1'b1;
                        n_state = ST_IDLE;
                    end else if (r_op == OP_LD_NN_SP) begin
                        mem_we = 1'b1;
                        mem_wdata = r_sp[7:0];
                        n_op = OP_HALT;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    if (is_rr) begin
                        case (dst)
                            3'd0: n_bc[15:8] = src_val;
                            3'd1: n_bc[7:0]  = src_val;
                            3'd2: n_de[15:8] = src_val;
                            3'd3: n_de[7:0]  = src_val;
                            3'd4: n_hl[15:8] = src_val;
                            3'd5: n_hl[7:0]  = src_val;
                            default: n_a = src_val;
                        endcase
                    end else if (is_rn) begin
                        case (dst)
                            3'd0: n_bc[15:8] = r_lo;
                            3'd1: n_bc[7:0]  = r_lo;
                            3'd2: n_de[15:8] = r_lo;
                            3'd3: n_de[7:0]  = r_lo;
                            3'd4: n_hl[15:8] = r_lo;
                            3'd5: n_hl[7:0]  = r_lo;
                            default: n_a = r_lo;
                        endcase
                    end else begin
                        case (r_op)
                            OP_LD_BC_NN: n_bc = nn;
                            OP_LD_DE_NN: n_de = nn;
                            OP_LD_HL_NN: n_hl = nn;
                            OP_LD_SP_NN: n_sp = nn;
                            OP_LD_SP_HL: n_sp = r_hl;
                            OP_LD_HL_SPE: begin
                                n_hl = r_sp + ext;
                                n_f = {2'b00, sum_nib[4], sum_low[8], r_f[3:0]};
                            end
                            default: n_a = r_a;
                        endcase
                    end
                    n_done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DONE: begin
                // Read data has arrived, or second byte of the SP store
                if (r_req == REQ_READ) begin
                    n_rd = r_rdata;
                end else if (r_op == OP_HALT) begin
                    mem_addr = nn + 16'd1;
                    mem_wdata = r_sp[15:8];
                    mem_we = 1'b1;
                end else if (is_rr) begin
                    case (dst)
                        3'd0: n_bc[15:8] = r_rdata;
                        3'd1: n_bc[7:0]  = r_rdata;
                        3'd2: n_de[15:8] = r_rdata;
                        3'd3: n_de[7:0]  = r_rdata;
                        3'd4: n_hl[15:8] = r_rdata;
                        3'd5: n_hl[7:0]  = r_rdata;
                        default: n_a = r_rdata;
                    endcase
                end else begin
                    n_a = r_rdata;
                    if (r_op == OP_LD_A_HLD) n_hl = r_hl - 16'd1;
                    if (r_op == OP_LD_A_HLI) n_hl = r_hl + 16'd1;
                end
                n_done = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_cycles = r_cyc;
    assign o_unknown_opcode = r_unk;
    assign o_read_data = r_rd;
    assign o_acc = r_a;
    assign o_flags = r_f;
    assign o_pair_bc = r_bc;
    assign o_pair_de = r_de;
    assign o_pair_hl = r_hl;
    assign o_stack_ptr = r_sp;
    assign o_prog_ctr = r_pc;

    // An unknown opcode reports no cycles
    a_unk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_unknown_opcode |-> o_cycles == 5'd0)
        else $error("unknown opcode with nonzero cycles");
    // A result follows an accepted request and leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result while busy");
    // Host requests never move the program counter
    a_host_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy && r_req != REQ_EXEC |=> $stable(o_prog_ctr))
        else $error("program counter moved on a host request");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import ebc_pkg::*;

    // The only request code the package leaves unnamed: it changes nothing.
    localparam logic [1:0] REQ_IDLE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_req_type;
    logic [15:0] i_host_addr;
    logic [7:0]  i_host_data;
    logic        o_done;
    logic [4:0]  o_cycles;
    logic        o_unknown_opcode;
    logic [7:0]  o_read_data;
    logic [7:0]  o_acc;
    logic [7:0]  o_flags;
    logic [15:0] o_pair_bc;
    logic [15:0] o_pair_de;
    logic [15:0] o_pair_hl;
    logic [15:0] o_stack_ptr;
    logic [15:0] o_prog_ctr;

    typedef struct {
        logic [4:0]  cycles;
        logic        unknown;
        logic [7:0]  rdata;
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
        logic [15:0] pc;
    } t_cpu_result;

    // Architectural state as the testbench believes it to be.
    logic [7:0]  cpu_a, cpu_f;
    logic [15:0] cpu_bc, cpu_de, cpu_hl, cpu_sp, cpu_pc;
    logic [7:0]  mem_image [0:65535];
    bit          mem_known [0:65535];
    int          known_addrs[$];

    t_cpu_result pending_results[$];
    int          error_count;
    bit          no_gaps;

    eight_bit_cpu_load_store_unit u_dut (.*);

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Memory model helpers.
    function automatic logic [7:0] mem_load(logic [15:0] addr);
        return mem_image[addr];
    endfunction

    function automatic void mem_store(logic [15:0] addr, logic [7:0] v);
        mem_image[addr] = v;
        if (!mem_known[addr]) begin
            mem_known[addr] = 1'b1;
            known_addrs.push_back(addr);
        end
    endfunction

    function automatic logic [7:0] fetch_byte();
        logic [7:0] v;
        v = mem_load(cpu_pc);
        cpu_pc = cpu_pc + 16'd1;
        return v;
    endfunction

    function automatic logic [7:0] read_operand(logic [2:0] code);
        case (code)
            3'd0: return cpu_bc[15:8];
            3'd1: return cpu_bc[7:0];
            3'd2: return cpu_de[15:8];
            3'd3: return cpu_de[7:0];
            3'd4: return cpu_hl[15:8];
            3'd5: return cpu_hl[7:0];
            OPND_MEM: return mem_load(cpu_hl);
            default: return cpu_a;
        endcase
    endfunction

    function automatic void write_operand(logic [2:0] code, logic [7:0] v);
        case (code)
            3'd0: cpu_bc[15:8] = v;
            3'd1: cpu_bc[7:0] = v;
            3'd2: cpu_de[15:8] = v;
            3'd3: cpu_de[7:0] = v;
            3'd4: cpu_hl[15:8] = v;
            3'd5: cpu_hl[7:0] = v;
            OPND_MEM: mem_store(cpu_hl, v);
            default: cpu_a = v;
        endcase
    endfunction

    // Executes one instruction on the predicted state; returns its clock cycles.
    function automatic logic [4:0] run_load(logic [7:0] op);
        logic [2:0]  dst, src;
        logic [15:0] nn;
        logic [7:0]  n, fl;
        dst = op[5:3];
        src = op[2:0];
        if (op >= 8'h40 && op <= 8'h7F && op != OP_HALT) begin
            write_operand(dst, read_operand(src));
            return (dst == OPND_MEM || src == OPND_MEM) ? 5'd8 : 5'd4;
        end
        if (op < 8'h40 && src == OPND_MEM) begin
            write_operand(dst, fetch_byte());
            return (dst == OPND_MEM) ? 5'd12 : 5'd8;
        end
        case (op)
            OP_LD_A_BC:  begin cpu_a = mem_load(cpu_bc); return 5'd8; end
            OP_LD_A_DE:  begin cpu_a = mem_load(cpu_de); return 5'd8; end
            OP_LD_A_NN: begin
                nn[7:0] = fetch_byte(); nn[15:8] = fetch_byte();
                cpu_a = mem_load(nn);
                return 5'd16;
            end
            OP_LD_BC_A:  begin mem_store(cpu_bc, cpu_a); return 5'd8; end
            OP_LD_DE_A:  begin mem_store(cpu_de, cpu_a); return 5'd8; end
            OP_LD_NN_A: begin
                nn[7:0] = fetch_byte(); nn[15:8] = fetch_byte();
                mem_store(nn, cpu_a);
                return 5'd16;
            end
            OP_LD_A_CIO: begin cpu_a = mem_load({HIGH_PAGE, cpu_bc[7:0]}); return 5'd8; end
            OP_LD_CIO_A: begin mem_store({HIGH_PAGE, cpu_bc[7:0]}, cpu_a); return 5'd8; end
            OP_LD_A_HLD: begin cpu_a = mem_load(cpu_hl); cpu_hl -= 16'd1; return 5'd8; end
            OP_LD_HLD_A: begin mem_store(cpu_hl, cpu_a); cpu_hl -= 16'd1; return 5'd8; end
            OP_LD_A_HLI: begin cpu_a = mem_load(cpu_hl); cpu_hl += 16'd1; return 5'd8; end
            OP_LD_HLI_A: begin mem_store(cpu_hl, cpu_a); cpu_hl += 16'd1; return 5'd8; end
            OP_LDH_N_A: begin n = fetch_byte(); mem_store({HIGH_PAGE, n}, cpu_a); return 5'd12; end
            OP_LDH_A_N: begin n = fetch_byte(); cpu_a = mem_load({HIGH_PAGE, n}); return 5'd12; end
            OP_LD_BC_NN, OP_LD_DE_NN, OP_LD_HL_NN, OP_LD_SP_NN: begin
                nn[7:0] = fetch_byte(); nn[15:8] = fetch_byte();
                case (op)
                    OP_LD_BC_NN: cpu_bc = nn;
                    OP_LD_DE_NN: cpu_de = nn;
                    OP_LD_HL_NN: cpu_hl = nn;
                    default:     cpu_sp = nn;
                endcase
                return 5'd12;
            end
            OP_LD_SP_HL: begin cpu_sp = cpu_hl; return 5'd8; end
            OP_LD_HL_SPE: begin
                // Signed offset; half carry comes from the low nibble sum, full carry from the low byte sum.
                n  = fetch_byte();
                fl = {4'h0, cpu_f[3:0]};
                if ({1'b0, cpu_sp[3:0]} + {1'b0, n[3:0]} > 5'h0F) fl[5] = 1'b1;
                if ({1'b0, cpu_sp[7:0]} + {1'b0, n} > 9'h0FF) fl[4] = 1'b1;
                cpu_hl = cpu_sp + {{8{n[7]}}, n};
                cpu_f  = fl;
                return 5'd12;
            end
            OP_LD_NN_SP: begin
                nn[7:0] = fetch_byte(); nn[15:8] = fetch_byte();
                mem_store(nn, cpu_sp[7:0]);
                mem_store(nn + 16'd1, cpu_sp[15:8]);
                return 5'd20;
            end
            default: return 5'd0;
        endcase
    endfunction

    // Works out the result of one accepted transaction and queues it.
    function automatic void predict_transaction(logic [1:0] req, logic [15:0] addr,
                                                logic [7:0] data);
        t_cpu_result r;
        r.cycles = 5'd0;
        r.unknown = 1'b0;
        r.rdata = 8'd0;
        case (req)
            REQ_EXEC: begin
                r.cycles  = run_load(fetch_byte());
                r.unknown = (r.cycles == 5'd0);
            end
            REQ_WRITE: mem_store(addr, data);
            REQ_READ:  r.rdata = mem_load(addr);
            default: ;
        endcase
        r.acc = cpu_a;
        r.flags = cpu_f;
        r.bc = cpu_bc;
        r.de = cpu_de;
        r.hl = cpu_hl;
        r.sp = cpu_sp;
        r.pc = cpu_pc;
        pending_results.push_back(r);
    endfunction

    // Sends one transaction after a random gap, then waits for acceptance.
    task automatic send_request(logic [1:0] req, logic [15:0] addr, logic [7:0] data);
        int sel, gap;
        sel = $urandom_range(0, 9);
        gap = (no_gaps || sel < 5) ? 0 : (sel < 9) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_req_type  <= req;
        i_host_addr <= addr;
        i_host_data <= data;
        do @(posedge i_clk); while (o_busy);
        predict_transaction(req, addr, data);
    endtask

    function automatic int operand_bytes(logic [7:0] op);
        if (op < 8'h40 && op[2:0] == OPND_MEM) return 1;
        case (op)
            OP_LDH_N_A, OP_LDH_A_N, OP_LD_HL_SPE: return 1;
            OP_LD_A_NN, OP_LD_NN_A, OP_LD_BC_NN, OP_LD_DE_NN, OP_LD_HL_NN,
            OP_LD_SP_NN, OP_LD_NN_SP: return 2;
            default: return 0;
        endcase
    endfunction

    // Places an instruction at PC, together with any byte it will read, then runs it.
    // The data byte goes in first so that the instruction bytes always survive.
    task automatic run_instruction(logic [7:0] op, logic [15:0] imm);
        bit          reads_mem;
        logic [15:0] daddr;
        int          nbytes;
        reads_mem = 1'b1;
        daddr = cpu_hl;
        nbytes = operand_bytes(op);
        if (op >= 8'h40 && op <= 8'h7F && op != OP_HALT && op[2:0] == OPND_MEM)
            daddr = cpu_hl;
        else begin
            case (op)
                OP_LD_A_BC:  daddr = cpu_bc;
                OP_LD_A_DE:  daddr = cpu_de;
                OP_LD_A_NN:  daddr = imm;
                OP_LD_A_CIO: daddr = {HIGH_PAGE, cpu_bc[7:0]};
                OP_LDH_A_N:  daddr = {HIGH_PAGE, imm[7:0]};
                OP_LD_A_HLD, OP_LD_A_HLI: daddr = cpu_hl;
                default: reads_mem = 1'b0;
            endcase
        end
        if (reads_mem && (!mem_known[daddr] || $urandom_range(0, 1)))
            send_request(REQ_WRITE, daddr, 8'($urandom));
        send_request(REQ_WRITE, cpu_pc, op);
        if (nbytes > 0) send_request(REQ_WRITE, cpu_pc + 16'd1, imm[7:0]);
        if (nbytes > 1) send_request(REQ_WRITE, cpu_pc + 16'd2, imm[15:8]);
        send_request(REQ_EXEC, 16'($urandom), 8'($urandom));
    endtask

    // Result checker: every strobed result is matched against the oldest prediction.
    function automatic void check_field(string name, logic [15:0] exp, logic [15:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_cpu_result r;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual pc %h",
                         $time, o_prog_ctr);
                error_count++;
            end else begin
                r = pending_results.pop_front();
                check_field("cycles", r.cycles, o_cycles);
                check_field("unknown_opcode", r.unknown, o_unknown_opcode);
                check_field("read_data", r.rdata, o_read_data);
                check_field("acc", r.acc, o_acc);
                check_field("flags", r.flags, o_flags);
                check_field("pair_bc", r.bc, o_pair_bc);
                check_field("pair_de", r.de, o_pair_de);
                check_field("pair_hl", r.hl, o_pair_hl);
                check_field("stack_ptr", r.sp, o_stack_ptr);
                check_field("prog_ctr", r.pc, o_prog_ctr);
            end
        end
    end

    // Register file after reset, seen through an idle request.
    task automatic test_reset_state();
        send_request(REQ_IDLE, 16'hFFFF, 8'hFF);
    endtask

    // Host writes and reads at the ends of the address and data ranges.
    task automatic test_host_access();
        send_request(REQ_WRITE, 16'h0000, 8'hFF);
        send_request(REQ_WRITE, 16'hFFFF, 8'h00);
        send_request(REQ_READ, 16'h0000, 8'h00);
        send_request(REQ_READ, 16'hFFFF, 8'hFF);
    endtask

    // Every load form once, HALT and an unknown opcode, plus the wrap and carry corner cases.
    task automatic test_load_forms();
        logic [7:0] ops[] = '{8'h41, 8'h46, 8'h70, 8'h06, 8'h36, OP_LD_A_BC, OP_LD_A_DE,
            OP_LD_A_NN, OP_LD_BC_A, OP_LD_DE_A, OP_LD_NN_A, OP_LD_A_CIO, OP_LD_CIO_A,
            OP_LD_A_HLD, OP_LD_HLD_A, OP_LD_A_HLI, OP_LD_HLI_A, OP_LDH_N_A, OP_LDH_A_N,
            OP_LD_BC_NN, OP_LD_DE_NN, OP_LD_HL_NN, OP_LD_SP_NN, OP_LD_SP_HL, OP_LD_HL_SPE,
            OP_LD_NN_SP, OP_HALT, 8'hCB};
        foreach (ops[i]) run_instruction(ops[i], 16'($urandom));
        // HL wraps upwards and downwards.
        run_instruction(OP_LD_HL_NN, 16'hFFFF);
        run_instruction(OP_LD_HLI_A, 16'h0);
        run_instruction(OP_LD_A_HLD, 16'h0);
        // Offset added to SP with both carries, then a negative offset.
        run_instruction(OP_LD_SP_NN, 16'h00FF);
        run_instruction(OP_LD_HL_SPE, 16'h0001);
        run_instruction(OP_LD_HL_SPE, 16'h0080);
        run_instruction(OP_LD_NN_SP, 16'hFFFF);
    endtask

    function automatic logic [7:0] random_opcode();
        logic [7:0] named[] = '{OP_LD_A_BC, OP_LD_A_DE, OP_LD_A_NN, OP_LD_BC_A, OP_LD_DE_A,
            OP_LD_NN_A, OP_LD_A_CIO, OP_LD_CIO_A, OP_LD_A_HLD, OP_LD_HLD_A, OP_LD_A_HLI,
            OP_LD_HLI_A, OP_LDH_N_A, OP_LDH_A_N, OP_LD_BC_NN, OP_LD_DE_NN, OP_LD_HL_NN,
            OP_LD_SP_NN, OP_LD_SP_HL, OP_LD_HL_SPE, OP_LD_NN_SP};
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) return 8'($urandom_range(8'h40, 8'h7F));
        if (sel < 50) return {2'b00, 3'($urandom), OPND_MEM};
        if (sel < 90) return named[$urandom_range(0, named.size() - 1)];
        if (sel < 93) return OP_HALT;
        return 8'($urandom_range(8'h80, 8'hDF));
    endfunction

    // Mostly well-formed instructions with random content, with host traffic mixed in.
    task automatic test_random_traffic(int count);
        int sel;
        logic [15:0] imm;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            imm = 16'($urandom);
            if ($urandom_range(0, 7) == 0) imm = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            if (sel < 60)
                run_instruction(random_opcode(), imm);
            else if (sel < 78)
                send_request(REQ_WRITE, 16'($urandom), 8'($urandom));
            else if (sel < 95)
                send_request(REQ_READ,
                             16'(known_addrs[$urandom_range(0, known_addrs.size() - 1)]),
                             8'($urandom));
            else
                send_request(REQ_IDLE, 16'($urandom), 8'($urandom));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        int guard;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_req_type  <= REQ_IDLE;
        i_host_addr <= 16'h0;
        i_host_data <= 8'h0;
        error_count = 0;
        no_gaps = 1'b0;
        cpu_a = RST_A;
        cpu_f = RST_F;
        cpu_bc = RST_BC;
        cpu_de = RST_DE;
        cpu_hl = RST_HL;
        cpu_sp = RST_SP;
        cpu_pc = RST_PC;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_host_access();
        test_load_forms();
        // Each instruction costs several transactions, so this call comes to about 500 transactions.
        test_random_traffic(260);

        // Drain the outstanding results, then let the block sit quiet before the final report.
        i_start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (pending_results.size() != 0)
                $display("%0t: results missing, expected %0d more, actual 0",
                         $time, pending_results.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ebc_pkg.sv
rtl/core/eight_bit_cpu_load_store_unit.sv
tb/sv/testbench.sv
